### rtl/slfp_pkg.sv
// shared types and constants of the sync/length/xor frame parser
// no dependencies; used by slfp_core, the top level, the checker and the bench

package slfp_pkg;

	// parser phase, one-hot
	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_ID      = 5'b00010,
		PH_LEN     = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	// frame status codes
	localparam logic [1:0] ST_SPEED_OK    = 2'd0;
	localparam logic [1:0] ST_OTHER_OK    = 2'd1;
	localparam logic [1:0] ST_BAD_CHECK   = 2'd2;
	localparam logic [1:0] ST_SPEED_SHORT = 2'd3;

	// configuration register indexes
	localparam logic [7:0] REG_SYNC_VALUE     = 8'd0;
	localparam logic [7:0] REG_SPEED_FRAME_ID = 8'd1;

	// reset values of the configuration registers
	localparam logic [7:0] SYNC_VALUE_RST     = 8'hAA;
	localparam logic [7:0] SPEED_FRAME_ID_RST = 8'h01;

	// one completed frame as seen by the output register
	typedef struct packed {
		logic        done;
		logic [7:0]  id;
		logic [1:0]  status;
		logic [15:0] speed;
	} frame_res_t;

endpackage

### rtl/sync_length_xor_frame_parser.sv
// top level of the sync/length/xor frame parser: config registers and result register
// depends on slfp_pkg and slfp_core
//
// usage
//   in channel  : in_valid/in_ready with rx_byte, one received stream byte per word
//   out channel : out_valid/out_ready with frame_id, frame_status, speed_value,
//                 one word per completed frame (sync, id, length, payload, check)
//   cfg channel : cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
//                 sync byte value, index 1 the speed frame id, other indexes are dropped;
//                 cfg_ready is always high, write only while the parser is idle
//   throughput  : one byte per cycle unless stalled, set by one parser update per byte
//   result      : the result word shows on out_valid in the cycle after its check byte
//                 is accepted
//   stall       : a pending result holds in the output register; in_ready stays high
//                 while that register is empty or being drained this cycle, so a held
//                 result stops input for as long as out_ready is low
//   reset       : arst_n low puts the parser in sync hunt, clears the output register
//                 and restores sync value 0xAA and speed frame id 0x01

module sync_length_xor_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// frame results out
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_id,
	output logic [1:0]  frame_status,
	output logic [15:0] speed_value,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] sync_value_q;
	logic [7:0] speed_frame_id_q;
	logic       out_valid_q;
	logic       in_fire;
	slfp_pkg::frame_res_t res;

	// config writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q     <= slfp_pkg::SYNC_VALUE_RST;
			speed_frame_id_q <= slfp_pkg::SPEED_FRAME_ID_RST;
		end else if (cfg_valid) begin
			if (cfg_index == slfp_pkg::REG_SYNC_VALUE) begin
				sync_value_q <= cfg_data;
			end else if (cfg_index == slfp_pkg::REG_SPEED_FRAME_ID) begin
				speed_frame_id_q <= cfg_data;
			end
		end
	end

	// a byte may enter whenever the result register has room after this edge
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	slfp_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_fire      (in_fire),
		.rx_byte        (rx_byte),
		.sync_value     (sync_value_q),
		.speed_frame_id (speed_frame_id_q),
		.res            (res)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res.done;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only when a frame completes
	always_ff @(posedge clk) begin
		if (in_fire && res.done) begin
			frame_id     <= res.id;
			frame_status <= res.status;
			speed_value  <= res.speed;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/slfp_core.sv
// frame parser state machine: one byte in per accepted word
// depends on slfp_pkg

module slfp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_fire,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          sync_value,
	input  logic [7:0]          speed_frame_id,
	output slfp_pkg::frame_res_t res
);

	slfp_pkg::phase_t phase_q, phase_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] id_q, id_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cnt_q, cnt_d;
	logic [7:0] spd_hi_q, spd_hi_d;
	logic [7:0] spd_lo_q, spd_lo_d;
	logic [7:0] cnt_inc;

	assign cnt_inc = cnt_q + 8'd1;

	always_comb begin
		phase_d    = phase_q;
		xor_d      = xor_q;
		id_d       = id_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		spd_hi_d   = spd_hi_q;
		spd_lo_d   = spd_lo_q;
		res.done   = 1'b0;
		res.id     = id_q;
		res.status = slfp_pkg::ST_OTHER_OK;
		res.speed  = 16'd0;
		case (phase_q)
			slfp_pkg::PH_ID: begin
				id_d    = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				phase_d = slfp_pkg::PH_LEN;
			end
			slfp_pkg::PH_LEN: begin
				len_d   = rx_byte;
				cnt_d   = 8'd0;
				xor_d   = xor_q ^ rx_byte;
				phase_d = (rx_byte == 8'd0) ? slfp_pkg::PH_CHECK : slfp_pkg::PH_PAYLOAD;
			end
			slfp_pkg::PH_PAYLOAD: begin
				xor_d = xor_q ^ rx_byte;
				if (cnt_q == 8'd0) begin
					spd_hi_d = rx_byte;
				end else if (cnt_q == 8'd1) begin
					spd_lo_d = rx_byte;
				end
				cnt_d = cnt_inc;
				if (cnt_inc == len_q) begin
					phase_d = slfp_pkg::PH_CHECK;
				end
			end
			slfp_pkg::PH_CHECK: begin
				res.done = 1'b1;
				if (xor_q != rx_byte) begin
					res.status = slfp_pkg::ST_BAD_CHECK;
				end else if (id_q == speed_frame_id) begin
					if (len_q < 8'd2) begin
						res.status = slfp_pkg::ST_SPEED_SHORT;
					end else begin
						res.status = slfp_pkg::ST_SPEED_OK;
						res.speed  = {spd_hi_q, spd_lo_q};
					end
				end
				phase_d = slfp_pkg::PH_HUNT;
			end
			default: begin
				// hunting, and any broken phase code
				phase_d = slfp_pkg::PH_HUNT;
				if (rx_byte == sync_value) begin
					xor_d   = rx_byte;
					phase_d = slfp_pkg::PH_ID;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= slfp_pkg::PH_HUNT;
			xor_q    <= 8'd0;
			id_q     <= 8'd0;
			len_q    <= 8'd0;
			cnt_q    <= 8'd0;
			spd_hi_q <= 8'd0;
			spd_lo_q <= 8'd0;
		end else if (byte_fire) begin
			phase_q  <= phase_d;
			xor_q    <= xor_d;
			id_q     <= id_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			spd_hi_q <= spd_hi_d;
			spd_lo_q <= spd_lo_d;
		end
	end

endmodule

### rtl/slfp_checker.sv
// port level checks of the frame parser, bound to the top level
// depends on slfp_pkg and sync_length_xor_frame_parser

module slfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  frame_id,
	input logic [1:0]  frame_status,
	input logic [15:0] speed_value
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_id) &&
		$stable(frame_status) && $stable(speed_value))
		else $error("stalled result word changed");

	// speed only reported for a good speed frame
	a_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status != slfp_pkg::ST_SPEED_OK |-> speed_value == 16'd0)
		else $error("speed value set on a non-speed result");

	// an empty result register never blocks input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a drained result is not shown again without a new byte
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("result word repeated");

endmodule

bind sync_length_xor_frame_parser slfp_checker u_slfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.frame_id     (frame_id),
	.frame_status (frame_status),
	.speed_value  (speed_value)
);

### bench/tb_sync_length_xor_frame_parser.sv
// self-checking bench for sync_length_xor_frame_parser: framed byte stream in, frame results out
// depends on slfp_pkg and the parser rtl; own frame predictor, random stalls on both sides

module tb_sync_length_xor_frame_parser;

	// index codes the parser must drop
	localparam logic [7:0] REG_UNUSED_LO = 8'd2;
	localparam logic [7:0] REG_UNUSED_HI = 8'hFF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;
	localparam int IDLE_PCT = 24;

	// one expected result word
	typedef struct packed {
		logic [7:0]  id;
		logic [1:0]  status;
		logic [15:0] speed;
	} frame_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_id;
	logic [1:0]  frame_status;
	logic [15:0] speed_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [7:0]  cfg_data;

	sync_length_xor_frame_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_id     (frame_id),
		.frame_status (frame_status),
		.speed_value  (speed_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// stream bytes still to be driven, and frame results still owed by the parser
	logic [7:0]  stream_q[$];
	frame_word_t frame_q[$];

	// predictor copy of the config registers
	logic [7:0] sync_cfg  = slfp_pkg::SYNC_VALUE_RST;
	logic [7:0] speed_cfg = slfp_pkg::SPEED_FRAME_ID_RST;

	// predictor copy of the parser state
	slfp_pkg::phase_t parse_ph = slfp_pkg::PH_HUNT;
	logic [7:0] check_acc = '0;
	logic [7:0] hold_id   = '0;
	logic [7:0] pay_len   = '0;
	logic [7:0] pay_cnt   = '0;
	logic [7:0] speed_hi  = '0;
	logic [7:0] speed_lo  = '0;

	int idle_pct   = IDLE_PCT;
	int err_cnt    = 0;
	int cycle_cnt  = 0;
	bit word_taken = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advance the frame predictor by one accepted stream byte
	task automatic parse_byte(input logic [7:0] b);
		frame_word_t w;
		case (parse_ph)
			slfp_pkg::PH_ID: begin
				hold_id = b;
				check_acc ^= b;
				parse_ph = slfp_pkg::PH_LEN;
			end
			slfp_pkg::PH_LEN: begin
				pay_len = b;
				pay_cnt = '0;
				check_acc ^= b;
				// zero length goes straight to the check byte
				parse_ph = (b == 8'd0) ? slfp_pkg::PH_CHECK : slfp_pkg::PH_PAYLOAD;
			end
			slfp_pkg::PH_PAYLOAD: begin
				check_acc ^= b;
				// only the first two payload bytes carry the speed
				if (pay_cnt == 8'd0)
					speed_hi = b;
				else if (pay_cnt == 8'd1)
					speed_lo = b;
				pay_cnt = pay_cnt + 8'd1;
				if (pay_cnt == pay_len)
					parse_ph = slfp_pkg::PH_CHECK;
			end
			slfp_pkg::PH_CHECK: begin
				w.id = hold_id;
				w.speed = '0;
				// bad check wins over the short speed frame
				if (check_acc != b) begin
					w.status = slfp_pkg::ST_BAD_CHECK;
				end else if (hold_id == speed_cfg) begin
					if (pay_len < 8'd2) begin
						w.status = slfp_pkg::ST_SPEED_SHORT;
					end else begin
						w.status = slfp_pkg::ST_SPEED_OK;
						w.speed = {speed_hi, speed_lo};
					end
				end else begin
					w.status = slfp_pkg::ST_OTHER_OK;
				end
				frame_q.push_back(w);
				parse_ph = slfp_pkg::PH_HUNT;
			end
			default: begin
				// hunting: anything but the sync byte is dropped
				parse_ph = slfp_pkg::PH_HUNT;
				if (b == sync_cfg) begin
					check_acc = b;
					parse_ph = slfp_pkg::PH_ID;
				end
			end
		endcase
	endtask

	// queue one frame; first two payload bytes given, rest random, optional broken check
	task automatic queue_frame(input logic [7:0] id, input int len, input logic [7:0] p0,
			input logic [7:0] p1, input bit bad);
		logic [7:0] acc;
		logic [7:0] b;
		acc = sync_cfg ^ id ^ 8'(len);
		stream_q.push_back(sync_cfg);
		stream_q.push_back(id);
		stream_q.push_back(8'(len));
		for (int i = 0; i < len; i++) begin
			b = (i == 0) ? p0 : (i == 1) ? p1 : 8'($urandom);
			acc ^= b;
			stream_q.push_back(b);
		end
		if (bad)
			acc ^= 8'($urandom_range(255, 1));
		stream_q.push_back(acc);
	endtask

	// random mix: mostly good frames, some bad checks, line noise and cut-off frames
	task automatic queue_traffic(input int n_words);
		int start;
		int pick;
		int len;
		logic [7:0] id;
		logic [7:0] b;
		start = stream_q.size();
		while (stream_q.size() - start < n_words) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				// noise between frames, mostly not the sync byte
				repeat ($urandom_range(3, 1)) begin
					b = 8'($urandom);
					if (b == sync_cfg && $urandom_range(3) != 0)
						b = ~b;
					stream_q.push_back(b);
				end
			end else if (pick < 14) begin
				// frame cut off inside the payload; later bytes get swallowed
				stream_q.push_back(sync_cfg);
				stream_q.push_back(8'($urandom));
				stream_q.push_back(8'($urandom_range(8, 3)));
				repeat ($urandom_range(2, 1))
					stream_q.push_back(8'($urandom));
			end else begin
				id = ($urandom_range(1) == 0) ? speed_cfg : 8'($urandom);
				pick = $urandom_range(99);
				if (pick < 70)
					len = $urandom_range(3);
				else if (pick < 95)
					len = $urandom_range(12, 4);
				else
					len = $urandom_range(40, 13);
				queue_frame(id, len, 8'($urandom), 8'($urandom), $urandom_range(99) < 15);
			end
		end
	endtask

	// wait until every byte is in and every owed frame is out, plus the result latency
	task automatic wait_drained;
		do
			@(negedge clk);
		while (stream_q.size() != 0 || in_valid || frame_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// register write over the cfg channel, mirrored into the predictor on the handshake
	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == slfp_pkg::REG_SYNC_VALUE)
			sync_cfg = val;
		else if (idx == slfp_pkg::REG_SPEED_FRAME_ID)
			speed_cfg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stream driver: new word at the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || word_taken)) begin
			if (stream_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				rx_byte  <= stream_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// input capture: every accepted word goes through the predictor
	always @(posedge clk) begin
		word_taken = in_valid && in_ready;
		if (arst_n && word_taken)
			parse_byte(rx_byte);
	end

	// result monitor and cycle limit
	always @(posedge clk) begin
		frame_word_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d frames owed", $time, frame_q.size());
			$display("status: fail");
			$finish;
		end else if (arst_n && out_valid && out_ready) begin
			if (frame_q.size() == 0) begin
				$display("%0t unexpected frame word: id %0h status %0d speed %0h",
					$time, frame_id, frame_status, speed_value);
				err_cnt++;
			end else begin
				want = frame_q.pop_front();
				if (frame_id !== want.id) begin
					$display("%0t frame_id mismatch: expected %0h, actual %0h",
						$time, want.id, frame_id);
					err_cnt++;
				end
				if (frame_status !== want.status) begin
					$display("%0t frame_status mismatch: expected %0d, actual %0d",
						$time, want.status, frame_status);
					err_cnt++;
				end
				if (speed_value !== want.speed) begin
					$display("%0t speed_value mismatch: expected %0h, actual %0h",
						$time, want.speed, speed_value);
					err_cnt++;
				end
			end
		end
	end

	// sequencing of the run
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: sync 0xAA, speed id 0x01
		// stray bytes while hunting are dropped
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		// speed frame with extreme payload bytes
		queue_frame(speed_cfg, 2, 8'hFF, 8'h00, 1'b0);
		// other id, zero length payload
		queue_frame(8'hFF, 0, 8'h00, 8'h00, 1'b0);
		// speed frame one byte short
		queue_frame(speed_cfg, 1, 8'h80, 8'h00, 1'b0);
		// short speed frame with a bad check reports the bad check
		queue_frame(speed_cfg, 0, 8'h00, 8'h00, 1'b1);
		// speed frame with an extra payload byte folded into the check only
		queue_frame(speed_cfg, 3, 8'h00, 8'hFF, 1'b0);
		queue_traffic(50);
		wait_drained();

		// low extremes for the sync byte, high for the speed id
		write_reg(slfp_pkg::REG_SYNC_VALUE, 8'h00);
		write_reg(slfp_pkg::REG_SPEED_FRAME_ID, 8'hFF);
		queue_traffic(40);
		wait_drained();

		// the other extremes, and a long run with neither side idling
		write_reg(slfp_pkg::REG_SYNC_VALUE, 8'hFF);
		write_reg(slfp_pkg::REG_SPEED_FRAME_ID, 8'h00);
		idle_pct = 0;
		queue_traffic(60);
		wait_drained();

		// random settings; writes to unused indexes must change nothing
		idle_pct = IDLE_PCT;
		write_reg(slfp_pkg::REG_SYNC_VALUE, 8'($urandom));
		write_reg(slfp_pkg::REG_SPEED_FRAME_ID, 8'($urandom));
		write_reg(REG_UNUSED_LO, 8'($urandom));
		write_reg(REG_UNUSED_HI, 8'($urandom));
		queue_traffic(20);
		// longest payload the length byte allows
		queue_frame(speed_cfg, 255, 8'($urandom), 8'($urandom), 1'b0);
		queue_traffic(15);
		wait_drained();

		if (err_cnt == 0 && frame_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d frames never seen", err_cnt, frame_q.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sync_length_xor_frame_parser.f
rtl/slfp_pkg.sv
rtl/slfp_core.sv
rtl/sync_length_xor_frame_parser.sv
rtl/slfp_checker.sv
bench/tb_sync_length_xor_frame_parser.sv
